// ===== rtl/orl_pkg.sv =====
// shared types and codes for the ordered record list
package orl_pkg;

	// operation codes
	localparam logic [2:0] OP_INS_FRONT  = 3'd0;
	localparam logic [2:0] OP_INS_REAR   = 3'd1;
	localparam logic [2:0] OP_INS_AT     = 3'd2;
	localparam logic [2:0] OP_INS_SORTED = 3'd3;
	localparam logic [2:0] OP_DEL_FIRST  = 3'd4;
	localparam logic [2:0] OP_DEL_LAST   = 3'd5;
	localparam logic [2:0] OP_DEL_AT     = 3'd6;
	localparam logic [2:0] OP_READ_AT    = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	// what the sequencer does with an accepted command
	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_TRIM   = 3'd1;
	localparam logic [2:0] ACT_INSERT = 3'd2;
	localparam logic [2:0] ACT_SEARCH = 3'd3;
	localparam logic [2:0] ACT_DELETE = 3'd4;
	localparam logic [2:0] ACT_READ   = 3'd5;

	// where the insert or delete lands
	localparam logic [1:0] TGT_ZERO  = 2'd0;
	localparam logic [1:0] TGT_COUNT = 2'd1;
	localparam logic [1:0] TGT_POS   = 2'd2;

	typedef struct packed {
		logic [7:0]  age;
		logic [15:0] id;
		logic [3:0]  month;
		logic [11:0] year;
	} entry_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [5:0]  position;
		logic [7:0]  age_key;
		logic [15:0] id_number;
		logic [3:0]  birth_month;
		logic [11:0] birth_year;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  entry_count;
		logic [7:0]  read_age;
		logic [15:0] read_id;
		logic [3:0]  read_month;
		logic [11:0] read_year;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic pos_le_cnt;
		logic pos_lt_cnt;
	} flags_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] action;
		logic [1:0] tsel;
	} plan_t;

	function automatic result_t make_result(logic [1:0] st, logic [5:0] cnt, entry_t rd);
		result_t r;
		r.status      = st;
		r.entry_count = cnt;
		r.read_age    = rd.age;
		r.read_id     = rd.id;
		r.read_month  = rd.month;
		r.read_year   = rd.year;
		return r;
	endfunction

endpackage

// ===== rtl/orl_ram.sv =====
// single-port-write, registered-read record memory
module orl_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  orl_pkg::entry_t     wdata,
	input  logic [AW-1:0]       raddr,
	output orl_pkg::entry_t     rdata
);

	orl_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/orl_decode.sv =====
// command check: picks status, action and target kind
module orl_decode (
	input  logic [2:0]      opcode,
	input  orl_pkg::flags_t flags,
	output orl_pkg::plan_t  plan
);

	always_comb begin
		plan.status = orl_pkg::ST_OK;
		plan.action = orl_pkg::ACT_NONE;
		plan.tsel   = orl_pkg::TGT_POS;
		unique case (opcode)
			orl_pkg::OP_INS_FRONT: begin
				plan.tsel = orl_pkg::TGT_ZERO;
				if (flags.full) plan.status = orl_pkg::ST_FULL;
				else plan.action = orl_pkg::ACT_INSERT;
			end
			orl_pkg::OP_INS_REAR: begin
				plan.tsel = orl_pkg::TGT_COUNT;
				if (flags.full) plan.status = orl_pkg::ST_FULL;
				else plan.action = orl_pkg::ACT_INSERT;
			end
			orl_pkg::OP_INS_AT: begin
				// bad position wins over full
				if (!flags.pos_le_cnt) plan.status = orl_pkg::ST_BADPOS;
				else if (flags.full) plan.status = orl_pkg::ST_FULL;
				else plan.action = orl_pkg::ACT_INSERT;
			end
			orl_pkg::OP_INS_SORTED: begin
				if (flags.full) plan.status = orl_pkg::ST_FULL;
				else plan.action = orl_pkg::ACT_SEARCH;
			end
			orl_pkg::OP_DEL_FIRST: begin
				plan.tsel = orl_pkg::TGT_ZERO;
				if (flags.empty) plan.status = orl_pkg::ST_EMPTY;
				else plan.action = orl_pkg::ACT_DELETE;
			end
			orl_pkg::OP_DEL_LAST: begin
				if (flags.empty) plan.status = orl_pkg::ST_EMPTY;
				else plan.action = orl_pkg::ACT_TRIM;
			end
			orl_pkg::OP_DEL_AT: begin
				if (!flags.pos_lt_cnt) plan.status = orl_pkg::ST_BADPOS;
				else plan.action = orl_pkg::ACT_DELETE;
			end
			orl_pkg::OP_READ_AT: begin
				if (!flags.pos_lt_cnt) plan.status = orl_pkg::ST_BADPOS;
				else plan.action = orl_pkg::ACT_READ;
			end
		endcase
	end

endmodule

// ===== rtl/ordered_record_list.sv =====
// top level of the ordered record list: sequencer around the record memory
//
// usage
// - commands come in on item with start; a command is taken on a clock edge
//   where start is high and busy is low, one command at a time
// - every command gives exactly one result on result, marked by done for one
//   cycle; there is no back-pressure, the receiver must take it then
// - errors, del_last and failed reads: result in the cycle after the transfer
// - read_at: result after one memory read, through the S_READ state
// - insert at index t with n entries: the later entries move up one per cycle
//   through the single read and write port
// - sorted insert: a scan finds the slot, then as above
// - the slowest command is a sorted insert into a list one short of full:
//   the scan and the one-entry-per-cycle shift between them pass every entry
// - busy is high after the transfer until the cycle done is shown (never for
//   errors and del_last); a new command may be taken in the same cycle as done
// - reset clears the entry count; memory contents need no clearing since only
//   entries below the count are ever used
module ordered_record_list #(
	parameter int CAPACITY = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  orl_pkg::item_t   item,
	output logic             done,
	output orl_pkg::result_t result
);

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 6) ? CW : 6;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_UP     = 3'd2;
	localparam logic [2:0] S_DOWN   = 3'd3;
	localparam logic [2:0] S_READ   = 3'd4;

	logic [2:0]       state_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    k_q;      // next slot to fill in a shift, next index to read in a scan
	logic [CW-1:0]    tgt_q;    // slot being opened for the insert
	orl_pkg::entry_t  rec_q;    // record to insert
	logic             v_s1;     // a read is in flight for a shift or scan
	logic [AW-1:0]    dst_s1;   // where that read's data goes (or its index)
	logic             done_q;
	orl_pkg::result_t result_q;

	orl_pkg::flags_t  flags;
	orl_pkg::plan_t   plan;
	logic [CMPW-1:0]  pos_ext;
	logic [CMPW-1:0]  cnt_ext;
	logic [CW-1:0]    target;
	logic             accept;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	orl_pkg::entry_t  ram_wdata;
	logic [AW-1:0]    ram_raddr;
	orl_pkg::entry_t  ram_rdata;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// range checks against the current count
	assign pos_ext          = CMPW'(item.position);
	assign cnt_ext          = CMPW'(cnt_q);
	assign flags.full       = (cnt_q == CW'(CAPACITY));
	assign flags.empty      = (cnt_q == '0);
	assign flags.pos_le_cnt = (pos_ext <= cnt_ext);
	assign flags.pos_lt_cnt = (pos_ext < cnt_ext);

	orl_decode u_decode (
		.opcode (item.opcode),
		.flags  (flags),
		.plan   (plan)
	);

	always_comb begin
		unique case (plan.tsel)
			orl_pkg::TGT_ZERO:  target = '0;
			orl_pkg::TGT_COUNT: target = cnt_q;
			default:            target = pos_ext[CW-1:0];
		endcase
	end

	// memory port steering
	always_comb begin
		unique case (state_q)
			S_SEARCH: ram_raddr = k_q[AW-1:0];
			S_UP:     ram_raddr = AW'(k_q - CW'(1));
			S_DOWN:   ram_raddr = AW'(k_q + CW'(1));
			default:  ram_raddr = pos_ext[AW-1:0];
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = dst_s1;
		ram_wdata = ram_rdata;
		if (v_s1 && (state_q == S_UP || state_q == S_DOWN)) begin
			// shifted entry lands one slot away from where it was read
			ram_we = 1'b1;
		end else if (state_q == S_UP && k_q == tgt_q) begin
			// gap is open: drop in the new record
			ram_we    = 1'b1;
			ram_waddr = tgt_q[AW-1:0];
			ram_wdata = rec_q;
		end
	end

	orl_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					v_s1 <= 1'b0;
					if (accept) begin
						unique case (plan.action)
							orl_pkg::ACT_TRIM: begin
								cnt_q  <= cnt_q - CW'(1);
								done_q <= 1'b1;
							end
							orl_pkg::ACT_INSERT: begin
								tgt_q   <= target;
								k_q     <= cnt_q;
								state_q <= S_UP;
							end
							orl_pkg::ACT_SEARCH: begin
								k_q     <= '0;
								state_q <= S_SEARCH;
							end
							orl_pkg::ACT_DELETE: begin
								k_q     <= target;
								state_q <= S_DOWN;
							end
							orl_pkg::ACT_READ: begin
								state_q <= S_READ;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SEARCH: begin
					// scan in order, stop at the first strictly greater age
					if (v_s1 && ram_rdata.age > rec_q.age) begin
						tgt_q   <= CW'(dst_s1);
						k_q     <= cnt_q;
						v_s1    <= 1'b0;
						state_q <= S_UP;
					end else if (k_q < cnt_q) begin
						v_s1   <= 1'b1;
						dst_s1 <= k_q[AW-1:0];
						k_q    <= k_q + CW'(1);
					end else begin
						v_s1 <= 1'b0;
						if (!v_s1) begin
							tgt_q   <= cnt_q;
							k_q     <= cnt_q;
							state_q <= S_UP;
						end
					end
				end
				S_UP: begin
					if (k_q > tgt_q) begin
						v_s1   <= 1'b1;
						dst_s1 <= k_q[AW-1:0];
						k_q    <= k_q - CW'(1);
					end else begin
						v_s1 <= 1'b0;
						if (!v_s1) begin
							cnt_q   <= cnt_q + CW'(1);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_DOWN: begin
					if ((k_q + CW'(1)) < cnt_q) begin
						v_s1   <= 1'b1;
						dst_s1 <= k_q[AW-1:0];
						k_q    <= k_q + CW'(1);
					end else begin
						v_s1 <= 1'b0;
						if (!v_s1) begin
							cnt_q   <= cnt_q - CW'(1);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_READ: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register, loaded wherever done is raised
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			rec_q.age   <= item.age_key;
			rec_q.id    <= item.id_number;
			rec_q.month <= item.birth_month;
			rec_q.year  <= item.birth_year;
			if (plan.action == orl_pkg::ACT_TRIM) begin
				result_q <= orl_pkg::make_result(orl_pkg::ST_OK, 6'(cnt_q - CW'(1)), '0);
			end else begin
				result_q <= orl_pkg::make_result(plan.status, 6'(cnt_q), '0);
			end
		end else if (state_q == S_UP) begin
			result_q <= orl_pkg::make_result(orl_pkg::ST_OK, 6'(cnt_q + CW'(1)), '0);
		end else if (state_q == S_DOWN) begin
			result_q <= orl_pkg::make_result(orl_pkg::ST_OK, 6'(cnt_q - CW'(1)), '0);
		end else if (state_q == S_READ) begin
			result_q <= orl_pkg::make_result(orl_pkg::ST_OK, 6'(cnt_q), ram_rdata);
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_no_insert_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP) |-> (cnt_q < CW'(CAPACITY)))
		else $error("insert shift started on a full list");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result shown while still working");

	a_shift_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP && v_s1 && k_q > tgt_q) |-> (ram_waddr != ram_raddr))
		else $error("shift write hits the entry being read");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1))
			|| (cnt_q + CW'(1) == $past(cnt_q)))
		else $error("entry count moved by more than one");

endmodule
